// ===== rtl/tpsw_pkg.sv =====
`default_nettype none
package tpsw_pkg;
    localparam int PLANE_COUNT = 7;
    localparam int PLANE_AW    = 3;
    localparam int VAL_W       = 32;
    localparam int COLOUR_W    = 24;
    localparam int ORIGIN_W    = 13;
    localparam int PIX_W       = 6;
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SHADE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

    localparam logic [PLANE_AW-1:0] PLANE_BARY0 = 3'd0;
    localparam logic [PLANE_AW-1:0] PLANE_BARY1 = 3'd1;
    localparam logic [PLANE_AW-1:0] PLANE_BARY2 = 3'd2;
    localparam logic [PLANE_AW-1:0] PLANE_RED   = 3'd3;
    localparam logic [PLANE_AW-1:0] PLANE_GREEN = 3'd4;
    localparam logic [PLANE_AW-1:0] PLANE_BLUE  = 3'd5;
    localparam logic [PLANE_AW-1:0] PLANE_INV_W = 3'd6;
    localparam logic [PLANE_AW-1:0] PLANE_NONE  = 3'd7;

    typedef logic [VAL_W-1:0] val_t;
endpackage
`default_nettype wire

// ===== rtl/triangle_pixel_shade_wbuffer_core.sv =====
// Perspective-correct pixel shader with a w-buffer over one tile. Items are taken one
// at a time: no new word is accepted until the last item is back in idle. A plane
// load is written straight from idle; a read waits on the tile memory, then loads the
// result word. A shade evaluates each plane in turn (a read, a multiply and a sum per
// plane through one plane memory and one pair of multipliers), then runs the depth
// test and loads the result word. When the depth test passes each colour channel is
// clamped or goes through the bit-serial colour divider, and one write into the tile
// memory follows. A held result word stretches any item that returns one.
// After reset a clearing pass zeroes the tile and plane memories; no item is taken
// meanwhile.
`default_nettype none
module triangle_pixel_shade_wbuffer_core
    import tpsw_pkg::*;
#(
    parameter int TILE_W = 64,
    parameter int TILE_H = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [2:0]           plane_index,
    input  wire logic signed [31:0]   plane_base,
    input  wire logic signed [31:0]   plane_step_x,
    input  wire logic signed [31:0]   plane_step_y,
    input  wire logic [PIX_W-1:0]     pixel_x,
    input  wire logic [PIX_W-1:0]     pixel_y,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic                 covered,
    output      logic                 written,
    output      logic [COLOUR_W-1:0]  colour,
    output      logic signed [31:0]   depth_value,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ORIGIN_W-1:0]  cfg_data
);
    localparam int CELLS = TILE_W * TILE_H;
    localparam int TAW   = $clog2(CELLS);
    localparam int SW    = ORIGIN_W + 1;
    localparam int PW    = 48;
    localparam int TWW   = COLOUR_W + VAL_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_PRD, ST_PMUL, ST_PSUM,
        ST_DTEST, ST_DSET, ST_DSTEP, ST_WRITE, ST_DONE
    } state_t;

    state_t                state_reg;
    logic [TAW-1:0]        clr_cnt_reg;
    logic [ORIGIN_W-1:0]   origin_x_reg, origin_y_reg;
    logic [1:0]            cmd_reg;
    logic                  inside_reg;
    logic [TAW-1:0]        cell_reg;
    logic [SW-1:0]         sx_reg, sy_reg;
    logic [PLANE_AW-1:0]   k_reg;
    logic signed [PW-1:0]  prod_x_reg, prod_y_reg;
    val_t                  base_reg;
    val_t                  vals_reg [PLANE_COUNT];
    logic [1:0]            ch_reg;
    logic [2:0]            bit_reg;
    logic [30:0]           rem_reg;
    logic [7:0]            low_reg, q_reg;
    logic                  res_cov_reg, res_wr_reg;
    logic [COLOUR_W-1:0]   res_col_reg;
    val_t                  res_dep_reg;
    logic                  out_valid_reg, cov_out_reg, wr_out_reg;
    logic [COLOUR_W-1:0]   col_out_reg;
    val_t                  dep_out_reg;

    logic                  accept, inside_in;
    logic [TAW-1:0]        cell_in;
    logic                  pl_we, tl_we, tl_re;
    logic [PLANE_AW-1:0]   pl_waddr;
    logic [3*VAL_W-1:0]    pl_wdata, pl_rdata;
    logic [TAW-1:0]        tl_waddr;
    logic [TWW-1:0]        tl_wdata, tl_rdata;
    logic signed [PW-1:0]  sum;
    val_t                  sat;
    val_t                  w_val, c_val, tile_dep;
    logic [38:0]           num;
    logic [31:0]           trial;
    logic                  trial_ge;
    logic                  cov_now;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign inside_in = (32'(pixel_x) < TILE_W) && (32'(pixel_y) < TILE_H);
    assign cell_in   = TAW'(TAW'(pixel_y) * TAW'(TILE_W) + TAW'(pixel_x));

    // plane memory {base, step_x, step_y}
    assign pl_we    = (state_reg == ST_CLEAR) ? (clr_cnt_reg[TAW-1:PLANE_AW] == '0)
                    : (accept && cmd == CMD_LOAD && plane_index != PLANE_NONE);
    assign pl_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg[PLANE_AW-1:0] : plane_index;
    assign pl_wdata = (state_reg == ST_CLEAR) ? '0
                    : {plane_base, plane_step_x, plane_step_y};

    tpsw_ram #(.WIDTH(3 * VAL_W), .DEPTH(2 ** PLANE_AW)) u_plane_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (state_reg == ST_PRD),
        .raddr (k_reg),
        .rdata (pl_rdata)
    );

    // tile memory {colour, depth}
    assign w_val    = vals_reg[PLANE_INV_W];
    assign tl_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign tl_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : cell_reg;
    assign tl_wdata = (state_reg == ST_CLEAR) ? '0 : {res_col_reg, w_val};
    assign tl_re    = accept && (cmd == CMD_SHADE || cmd == CMD_READ);

    tpsw_ram #(.WIDTH(TWW), .DEPTH(CELLS)) u_tile_ram (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_waddr),
        .wdata (tl_wdata),
        .re    (tl_re),
        .raddr (cell_in),
        .rdata (tl_rdata)
    );
    assign tile_dep = tl_rdata[VAL_W-1:0];

    // sum and saturate to 32 bits
    assign sum = PW'($signed(base_reg)) + prod_x_reg + prod_y_reg;
    always_comb
    begin
        if (sum[PW-1:VAL_W-1] == '0 || sum[PW-1:VAL_W-1] == '1)
        begin
            sat = sum[VAL_W-1:0];
        end
        else if (sum[PW-1])
        begin
            sat = 32'h8000_0000;
        end
        else
        begin
            sat = 32'h7FFF_FFFF;
        end
    end

    assign cov_now = !vals_reg[PLANE_BARY0][VAL_W-1] && !vals_reg[PLANE_BARY1][VAL_W-1]
                  && !vals_reg[PLANE_BARY2][VAL_W-1];
    assign c_val   = vals_reg[PLANE_RED + PLANE_AW'(ch_reg)];
    // c*255, c known positive and below w
    assign num      = {c_val[30:0], 8'd0} - {8'd0, c_val[30:0]};
    assign trial    = {rem_reg, low_reg[7]};
    assign trial_ge = (trial >= w_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cmd_reg       <= CMD_LOAD;
            inside_reg    <= 1'b0;
            cell_reg      <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            k_reg         <= '0;
            prod_x_reg    <= '0;
            prod_y_reg    <= '0;
            base_reg      <= '0;
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                vals_reg[i] <= '0;
            end
            ch_reg        <= '0;
            bit_reg       <= '0;
            rem_reg       <= '0;
            low_reg       <= '0;
            q_reg         <= '0;
            res_cov_reg   <= 1'b0;
            res_wr_reg    <= 1'b0;
            res_col_reg   <= '0;
            res_dep_reg   <= '0;
            out_valid_reg <= 1'b0;
            cov_out_reg   <= 1'b0;
            wr_out_reg    <= 1'b0;
            col_out_reg   <= '0;
            dep_out_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    default:      ;
                endcase
            end
            // the done state loads or keeps the result word itself
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == CELLS - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= cmd;
                        inside_reg <= inside_in;
                        cell_reg   <= cell_in;
                        sx_reg     <= SW'(origin_x_reg) + SW'(pixel_x);
                        sy_reg     <= SW'(origin_y_reg) + SW'(pixel_y);
                        k_reg      <= '0;
                        res_cov_reg <= 1'b0;
                        res_wr_reg  <= 1'b0;
                        if (cmd == CMD_SHADE)
                        begin
                            state_reg <= ST_PRD;
                        end
                        else if (cmd == CMD_READ)
                        begin
                            state_reg <= ST_RDWAIT;
                        end
                    end
                end
                ST_RDWAIT:
                begin
                    res_col_reg <= inside_reg ? tl_rdata[TWW-1:VAL_W] : '0;
                    res_dep_reg <= inside_reg ? tile_dep : '0;
                    state_reg   <= ST_DONE;
                end
                ST_PRD:
                begin
                    state_reg <= ST_PMUL;
                end
                ST_PMUL:
                begin
                    base_reg   <= pl_rdata[3*VAL_W-1:2*VAL_W];
                    prod_x_reg <= $signed(pl_rdata[2*VAL_W-1:VAL_W]) * $signed({1'b0, sx_reg});
                    prod_y_reg <= $signed(pl_rdata[VAL_W-1:0]) * $signed({1'b0, sy_reg});
                    state_reg  <= ST_PSUM;
                end
                ST_PSUM:
                begin
                    vals_reg[k_reg] <= sat;
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg == PLANE_INV_W) ? ST_DTEST : ST_PRD;
                end
                ST_DTEST:
                begin
                    res_cov_reg <= cov_now;
                    res_col_reg <= inside_reg ? tl_rdata[TWW-1:VAL_W] : '0;
                    res_dep_reg <= inside_reg ? tile_dep : '0;
                    ch_reg      <= '0;
                    if (cov_now && inside_reg && ($signed(w_val) > $signed(tile_dep)))
                    begin
                        state_reg <= ST_DSET;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DSET:
                begin
                    if (c_val[VAL_W-1] || c_val == '0)
                    begin
                        res_col_reg <= {res_col_reg[15:0], 8'd0};
                        ch_reg      <= ch_reg + 1'b1;
                        state_reg   <= (ch_reg == 2'd2) ? ST_WRITE : ST_DSET;
                    end
                    else if ($signed(c_val) >= $signed(w_val))
                    begin
                        res_col_reg <= {res_col_reg[15:0], 8'hFF};
                        ch_reg      <= ch_reg + 1'b1;
                        state_reg   <= (ch_reg == 2'd2) ? ST_WRITE : ST_DSET;
                    end
                    else
                    begin
                        rem_reg   <= num[38:8];
                        low_reg   <= num[7:0];
                        bit_reg   <= 3'd7;
                        state_reg <= ST_DSTEP;
                    end
                end
                ST_DSTEP:
                begin
                    // restoring division, one quotient bit a cycle
                    rem_reg <= trial_ge ? 31'(trial - w_val) : trial[30:0];
                    low_reg <= {low_reg[6:0], 1'b0};
                    q_reg   <= {q_reg[6:0], trial_ge};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        res_col_reg <= {res_col_reg[15:0], q_reg[6:0], trial_ge};
                        ch_reg      <= ch_reg + 1'b1;
                        state_reg   <= (ch_reg == 2'd2) ? ST_WRITE : ST_DSET;
                    end
                end
                ST_WRITE:
                begin
                    res_wr_reg  <= 1'b1;
                    res_dep_reg <= w_val;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        cov_out_reg   <= (cmd_reg == CMD_SHADE) && res_cov_reg;
                        wr_out_reg    <= res_wr_reg;
                        col_out_reg   <= res_col_reg;
                        dep_out_reg   <= res_dep_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign covered     = cov_out_reg;
    assign written     = wr_out_reg;
    assign colour      = col_out_reg;
    assign depth_value = dep_out_reg;
endmodule
`default_nettype wire

// ===== rtl/tpsw_ram.sv =====
`default_nettype none
module tpsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tpsw_chk.sv =====
`default_nettype none
module tpsw_chk
    import tpsw_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic [1:0]           cmd,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 covered,
    input wire logic                 written,
    input wire logic [COLOUR_W-1:0]  colour,
    input wire logic signed [31:0]   depth_value
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(colour) && $stable(depth_value))
        else $error("result word changed under stall");

    a_wr_cov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> covered)
        else $error("pixel written but not covered");

    // a stored w always beats a nonnegative depth, so it is positive
    a_wr_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> !depth_value[31] && depth_value != 0)
        else $error("written depth not positive");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_LOAD |=> !in_stall)
        else $error("plane load held the input");
endmodule

bind triangle_pixel_shade_wbuffer_core tpsw_chk u_tpsw_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .covered     (covered),
    .written     (written),
    .colour      (colour),
    .depth_value (depth_value)
);
`default_nettype wire
